// ===== hw/rtl/tbar_pkg.sv =====
package tbar_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_UP_PRESS   = 3'd1,
        OP_DOWN_PRESS = 3'd2,
        OP_UP_REL     = 3'd3,
        OP_DOWN_REL   = 3'd4,
        OP_LOAD       = 3'd5
    } t_op;

    localparam logic [2:0] CFG_FLOOR_BPM   = 3'd0;
    localparam logic [2:0] CFG_CEIL_BPM    = 3'd1;
    localparam logic [2:0] CFG_HOME_BPM    = 3'd2;
    localparam logic [2:0] CFG_REPEAT      = 3'd3;
    localparam logic [2:0] CFG_FAST_REPEAT = 3'd4;
    localparam logic [2:0] CFG_SAVE_DELAY  = 3'd5;

    localparam logic [8:0] RST_FLOOR_BPM   = 9'd20;
    localparam logic [8:0] RST_CEIL_BPM    = 9'd300;
    localparam logic [8:0] RST_HOME_BPM    = 9'd120;
    localparam logic [5:0] RST_REPEAT      = 6'd10;
    localparam logic [5:0] RST_FAST_REPEAT = 6'd50;
    localparam logic [9:0] RST_SAVE_DELAY  = 10'd600;

    localparam logic [6:0] HELD_MAX  = 7'd127;
    localparam logic [9:0] SINCE_MAX = 10'd1023;

    // Reciprocal of five in 18 fractional bits; exact for the 11-bit numerator used here.
    localparam logic [16:0] RECIP_FIVE = 17'd52429;

    typedef struct packed {
        logic [8:0] floor_bpm;
        logic [8:0] ceil_bpm;
        logic [8:0] home_bpm;
        logic [5:0] repeat_ticks;
        logic [5:0] fast_repeat_ticks;
        logic [9:0] save_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic        up_pressed;
        logic        down_pressed;
        logic [15:0] stored_word;
    } t_item;

    typedef struct packed {
        logic [8:0] tempo_now;
        logic       tempo_changed;
        logic       save_request;
        logic [8:0] toggle_rate;
    } t_result;

endpackage

// ===== hw/rtl/tempo_button_auto_repeat.sv =====
// Tempo controller with auto-repeating up and down buttons. Each request on the input
// stream (tick, press, release or load) produces exactly one result: the current tempo,
// whether the request changed it, whether it should be saved, and the derived toggle rate.
// A request is registered on acceptance and evaluated into the output register when that
// register is free or being read, so the block sustains one request per clock unless the
// output stalls; a single state update path lies between the input and output registers.
// A new request is accepted while a finished result waits, stalling only when both the
// input and output registers are full. Configuration writes are taken at any time and
// are meant to be issued while the block is idle.
module tempo_button_auto_repeat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // up_pressed [0], down_pressed [1], stored_word [17:2], zero [23:18]
    input  logic [23:0] s_axis_tdata,
    // op [2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tempo_now [8:0], tempo_changed [9], save_request [10], toggle_rate [19:11],
    // zero [23:20]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    tbar_pkg::t_cfg    w_cfg;
    tbar_pkg::t_item   r_item;
    tbar_pkg::t_result w_result;
    tbar_pkg::t_result r_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_step;
    logic              w_accept;

    assign o_cfg_ready   = 1'b1;
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tbar_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tbar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op           <= s_axis_tuser;
            r_item.up_pressed   <= s_axis_tdata[0];
            r_item.down_pressed <= s_axis_tdata[1];
            r_item.stored_word  <= s_axis_tdata[17:2];
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result.toggle_rate, r_result.save_request,
                            r_result.tempo_changed, r_result.tempo_now};

endmodule

// ===== hw/rtl/tbar_cfg.sv =====
module tbar_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [2:0]       i_wr_index,
    input  logic [9:0]       i_wr_data,
    output tbar_pkg::t_cfg   o_cfg
);

    tbar_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_bpm         <= tbar_pkg::RST_FLOOR_BPM;
            r_cfg.ceil_bpm          <= tbar_pkg::RST_CEIL_BPM;
            r_cfg.home_bpm          <= tbar_pkg::RST_HOME_BPM;
            r_cfg.repeat_ticks      <= tbar_pkg::RST_REPEAT;
            r_cfg.fast_repeat_ticks <= tbar_pkg::RST_FAST_REPEAT;
            r_cfg.save_delay_ticks  <= tbar_pkg::RST_SAVE_DELAY;
        end else if (i_wr_en) begin
            case (i_wr_index)
                tbar_pkg::CFG_FLOOR_BPM:   r_cfg.floor_bpm         <= i_wr_data[8:0];
                tbar_pkg::CFG_CEIL_BPM:    r_cfg.ceil_bpm          <= i_wr_data[8:0];
                tbar_pkg::CFG_HOME_BPM:    r_cfg.home_bpm          <= i_wr_data[8:0];
                tbar_pkg::CFG_REPEAT:      r_cfg.repeat_ticks      <= i_wr_data[5:0];
                tbar_pkg::CFG_FAST_REPEAT: r_cfg.fast_repeat_ticks <= i_wr_data[5:0];
                tbar_pkg::CFG_SAVE_DELAY:  r_cfg.save_delay_ticks  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/tbar_core.sv =====
module tbar_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tbar_pkg::t_item   i_item,
    input  tbar_pkg::t_cfg    i_cfg,
    output tbar_pkg::t_result o_result
);

    logic [8:0] r_tempo;
    logic [8:0] r_saved;
    logic [6:0] r_up;
    logic [6:0] r_dn;
    logic [9:0] r_since;
    logic       r_parity;
    logic       r_press;

    logic [8:0] n_tempo;
    logic [8:0] n_saved;
    logic [6:0] n_up;
    logic [6:0] n_dn;
    logic [9:0] n_since;
    logic       n_parity;
    logic       n_press;

    logic        w_apply;
    logic [15:0] w_cand;
    logic        w_is_tick;
    logic        w_is_load;
    logic [8:0]  w_load_val;
    logic        w_even;
    logic [6:0]  w_up0;
    logic [6:0] w_dn0;
    logic [6:0]  w_up_inc;
    logic [6:0]  w_dn_inc;
    logic [15:0] w_cand_up;
    logic [15:0] w_cand_dn;
    logic [8:0]  w_clamped;
    logic        w_changed;
    logic        w_save;
    logic [27:0] w_rate_prod;

    assign w_even    = !r_parity;
    assign w_up0     = i_item.up_pressed ? r_up : 7'd0;
    assign w_dn0     = i_item.down_pressed ? r_dn : 7'd0;
    assign w_up_inc  = (w_up0 >= tbar_pkg::HELD_MAX) ? tbar_pkg::HELD_MAX : w_up0 + 7'd1;
    assign w_dn_inc  = (w_dn0 >= tbar_pkg::HELD_MAX) ? tbar_pkg::HELD_MAX : w_dn0 + 7'd1;
    assign w_cand_up = {7'd0, r_tempo} + 16'd1;
    assign w_cand_dn = (r_tempo == 9'd0) ? 16'hFFFF : {7'd0, r_tempo - 9'd1};
    assign w_load_val = (i_item.stored_word < {7'd0, i_cfg.floor_bpm} ||
                         i_item.stored_word > {7'd0, i_cfg.ceil_bpm}) ?
                        i_cfg.home_bpm : i_item.stored_word[8:0];

    always_comb begin
        w_apply   = 1'b0;
        w_cand    = w_cand_up;
        w_is_tick = 1'b0;
        w_is_load = 1'b0;
        n_up      = r_up;
        n_dn      = r_dn;
        n_parity  = r_parity;
        n_press   = r_press;
        case (tbar_pkg::t_op'(i_item.op))
            tbar_pkg::OP_TICK: begin
                w_is_tick = 1'b1;
                n_parity  = !r_parity;
                n_press   = 1'b0;
                n_up      = w_up0;
                n_dn      = w_dn0;
                if (i_item.up_pressed && i_item.down_pressed) begin
                    n_up = w_up_inc;
                    if (w_up_inc >= {1'b0, i_cfg.repeat_ticks}) begin
                        n_dn = w_dn_inc;
                        if (w_dn_inc >= {1'b0, i_cfg.repeat_ticks}) begin
                            n_up    = 7'd0;
                            n_dn    = 7'd0;
                            w_apply = 1'b1;
                            w_cand  = {7'd0, i_cfg.home_bpm};
                        end
                    end
                end else if (i_item.up_pressed) begin
                    n_up   = w_up_inc;
                    w_cand = w_cand_up;
                    if (w_up_inc >= {1'b0, i_cfg.fast_repeat_ticks}) begin
                        w_apply = 1'b1;
                        n_up    = {1'b0, i_cfg.fast_repeat_ticks};
                    end else if (w_up_inc >= {1'b0, i_cfg.repeat_ticks} && w_even) begin
                        w_apply = 1'b1;
                    end
                end else if (i_item.down_pressed) begin
                    n_dn   = w_dn_inc;
                    w_cand = w_cand_dn;
                    if (w_dn_inc >= {1'b0, i_cfg.fast_repeat_ticks}) begin
                        w_apply = 1'b1;
                        n_dn    = {1'b0, i_cfg.fast_repeat_ticks};
                    end else if (w_dn_inc >= {1'b0, i_cfg.repeat_ticks} && w_even) begin
                        w_apply = 1'b1;
                    end
                end
            end
            tbar_pkg::OP_UP_PRESS: begin
                w_cand = w_cand_up;
                if (!r_press) begin
                    n_press = 1'b1;
                    w_apply = (r_up == 7'd0);
                end
            end
            tbar_pkg::OP_DOWN_PRESS: begin
                w_cand = w_cand_dn;
                if (!r_press) begin
                    n_press = 1'b1;
                    w_apply = (r_dn == 7'd0);
                end
            end
            tbar_pkg::OP_UP_REL: begin
                n_up = 7'd0;
            end
            tbar_pkg::OP_DOWN_REL: begin
                n_dn = 7'd0;
            end
            tbar_pkg::OP_LOAD: begin
                w_is_load = 1'b1;
                w_apply   = 1'b1;
                w_cand    = {7'd0, w_load_val};
            end
            default: ;
        endcase
    end

    always_comb begin
        if (w_cand < {7'd0, i_cfg.floor_bpm}) begin
            w_clamped = i_cfg.floor_bpm;
        end else if (w_cand > {7'd0, i_cfg.ceil_bpm}) begin
            w_clamped = i_cfg.ceil_bpm;
        end else begin
            w_clamped = w_cand[8:0];
        end
        w_changed = w_apply && (w_clamped != r_tempo);
        n_tempo   = w_changed ? w_clamped : r_tempo;
        if (w_changed) begin
            n_since = 10'd0;
        end else if (w_is_tick && r_since < tbar_pkg::SINCE_MAX) begin
            n_since = r_since + 10'd1;
        end else begin
            n_since = r_since;
        end
        w_save = w_is_tick && w_even && (n_tempo != r_saved) &&
                 (n_since >= i_cfg.save_delay_ticks);
        if (w_is_load) begin
            n_saved = w_load_val;
        end else if (w_save) begin
            n_saved = n_tempo;
        end else begin
            n_saved = r_saved;
        end
    end

    assign w_rate_prod = {n_tempo, 2'b00} * tbar_pkg::RECIP_FIVE;

    always_comb begin
        o_result.tempo_now     = n_tempo;
        o_result.tempo_changed = w_changed;
        o_result.save_request  = w_save;
        o_result.toggle_rate   = w_rate_prod[26:18];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo  <= 9'd0;
            r_saved  <= 9'd0;
            r_up     <= 7'd0;
            r_dn     <= 7'd0;
            r_since  <= 10'd0;
            r_parity <= 1'b0;
            r_press  <= 1'b1;
        end else if (i_step) begin
            r_tempo  <= n_tempo;
            r_saved  <= n_saved;
            r_up     <= n_up;
            r_dn     <= n_dn;
            r_since  <= n_since;
            r_parity <= n_parity;
            r_press  <= n_press;
        end
    end

endmodule

// ===== hw/rtl/tbar_checker.sv =====
module tbar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [9:0]  i_cfg_data
);

    logic [12:0] w_rate5;
    logic [12:0] w_tempo4;

    assign w_rate5  = {4'd0, m_axis_tdata[19:11]} * 13'd5;
    assign w_tempo4 = {2'd0, m_axis_tdata[8:0], 2'b00};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result request changed or dropped.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("Block not empty after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input stalled while the output side was free.");

    a_rate_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_rate5 <= w_tempo4) && (w_tempo4 < w_rate5 + 13'd5))
        else $error("Toggle rate does not match tempo.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("Configuration write was refused.");

endmodule

bind tempo_button_auto_repeat tbar_checker u_tbar_checker (.*);
